// ===== src/fwfb_pkg.sv =====
// Shared types, constants and CRC helper for the flash write frame builder.
`timescale 1ns / 1ps
`default_nettype none

package fwfb_pkg;

  localparam int unsigned PayloadBytes = 32;
  localparam int unsigned LenExtra     = 10;
  localparam int unsigned PosW         = $clog2(PayloadBytes + 1);
  localparam int unsigned CrcStepsPerCycle = 8;

  localparam logic [PosW-1:0] PayloadPos = PosW'(PayloadBytes);
  localparam logic [7:0]  FrameLen     = 8'(PayloadBytes + LenExtra);
  localparam logic [7:0]  PayloadLen   = 8'(PayloadBytes);
  localparam logic [7:0]  PadByte      = 8'hFF;
  localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPolyReset = 32'h08C7_1CC1;
  localparam logic [31:0] PacketStride = 32'(PayloadBytes);

  typedef enum logic [2:0] {
    CFG_BASE_ADDRESS  = 3'd0,
    CFG_WRITE_COMMAND = 3'd1,
    CFG_START_KEY     = 3'd2,
    CFG_CRC_POLY      = 3'd3,
    CFG_SIGN_EXTEND   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_KEY  = 3'd0,
    KIND_LEN  = 3'd1,
    KIND_CMD  = 3'd2,
    KIND_ADDR = 3'd3,
    KIND_PLEN = 3'd4,
    KIND_DATA = 3'd5,
    KIND_PAD  = 3'd6,
    KIND_CRC  = 3'd7
  } kind_t;

  typedef struct packed {
    logic       cap;
    logic       emit;
    kind_t      kind;
    logic [1:0] idx;
    logic       take;
    logic       done;
    logic       last;
    logic       close;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic crc_busy;
    logic in_end;
  } sts_t;

  function automatic logic [31:0] crc_step8(input logic [31:0] crc, input logic [31:0] poly);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < CrcStepsPerCycle; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ poly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/flash_write_frame_builder_unit.sv =====
// Top level of the flash write frame builder: controller plus datapath.
//
// Image bytes enter on the in channel (image_byte, image_end); frame bytes
// leave on the out channel (frame_byte, frame_done, run_last), one beat per
// frame byte. Each input beat yields its payload beat; the first byte of a
// packet is preceded by eight header beats, and a full packet or image_end
// adds any 0xFF pad beats and four CRC beats. run_last marks the final beat
// caused by an input beat, frame_done the last CRC beat of a frame.
// Every byte covered by the CRC is taken in by the CRC unit, which folds
// eight polynomial steps per cycle; the next beat waits for it. Any beat
// that follows a folded byte therefore waits for the CRC unit, while CRC
// beats are not folded themselves. Configuration beats are taken on every
// cycle (cfg_ready is always high) and are to be sent only while the
// block is idle. Reset clears the address to zero, restores the register
// defaults and sets the CRC to all ones. A stalled receiver holds the
// output register; the block still accepts the next input beat, then
// waits before emitting.
`timescale 1ns / 1ps
`default_nettype none

module flash_write_frame_builder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  image_byte,
  input  wire logic        image_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic             frame_done,
  output logic             run_last
);

  fwfb_pkg::cmd_t cmd;
  fwfb_pkg::sts_t sts;

  fwfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwfb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .image_byte (image_byte),
    .image_end  (image_end),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_done (frame_done),
    .run_last   (run_last)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame_done beat not marked as last");

  a_no_emit_while_crc: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.crc_busy)
    else $error("beat emitted while CRC unit busy");

  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !in_ready)
    else $error("beat emitted while accepting input");
`endif

endmodule

`default_nettype wire

// ===== src/fwfb_ctrl.sv =====
// Frame sequencing controller: walks header, payload, padding and CRC beats.
`timescale 1ns / 1ps
`default_nettype none

module fwfb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fwfb_pkg::sts_t sts,
  output fwfb_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_DATA = 5'b00100,
    S_PAD  = 5'b01000,
    S_CRC  = 5'b10000
  } state_t;

  state_t                        state, state_next;
  logic [2:0]                    cnt, cnt_next;
  logic [fwfb_pkg::PosW-1:0]     pos, pos_next;
  logic [fwfb_pkg::PosW-1:0]     pos_inc;
  logic [1:0]                    addr_sel;

  assign pos_inc  = pos + fwfb_pkg::PosW'(1);
  assign addr_sel = cnt[1:0] - 2'd3;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.kind   = fwfb_pkg::KIND_KEY;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
        if (in_valid) begin
          cnt_next   = 3'd0;
          state_next = (pos == '0) ? S_HDR : S_DATA;
        end
      end
      S_HDR: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.take = (cnt != 3'd0);
          cmd.idx  = addr_sel;
          case (cnt)
            3'd0:                      cmd.kind = fwfb_pkg::KIND_KEY;
            3'd1:                      cmd.kind = fwfb_pkg::KIND_LEN;
            3'd2:                      cmd.kind = fwfb_pkg::KIND_CMD;
            3'd3, 3'd4, 3'd5, 3'd6:    cmd.kind = fwfb_pkg::KIND_ADDR;
            default:                   cmd.kind = fwfb_pkg::KIND_PLEN;
          endcase
          cnt_next = cnt + 3'd1;
          if (cnt == 3'd7) begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.take = 1'b1;
          cmd.kind = fwfb_pkg::KIND_DATA;
          pos_next = pos_inc;
          cnt_next = 3'd0;
          if (sts.in_end || pos_inc >= fwfb_pkg::PayloadPos) begin
            state_next = (pos_inc < fwfb_pkg::PayloadPos) ? S_PAD : S_CRC;
          end else begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.take = 1'b1;
          cmd.kind = fwfb_pkg::KIND_PAD;
          pos_next = pos_inc;
          cnt_next = 3'd0;
          if (pos_inc >= fwfb_pkg::PayloadPos) begin
            state_next = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.kind = fwfb_pkg::KIND_CRC;
          cmd.idx  = cnt[1:0];
          cnt_next = cnt + 3'd1;
          if (cnt[1:0] == 2'd3) begin
            cmd.done   = 1'b1;
            cmd.last   = 1'b1;
            cmd.close  = 1'b1;
            pos_next   = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 3'd0;
      pos   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/fwfb_datapath.sv =====
// Datapath: configuration registers, byte select, CRC unit and output register.
`timescale 1ns / 1ps
`default_nettype none

module fwfb_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic [7:0]     image_byte,
  input  wire logic           image_end,
  input  wire fwfb_pkg::cmd_t cmd,
  output fwfb_pkg::sts_t      sts,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          frame_byte,
  output logic                frame_done,
  output logic                run_last
);

  logic [31:0] packet_address;
  logic [7:0]  command_code;
  logic [7:0]  start_key;
  logic [31:0] crc_poly;
  logic        sign_ext;
  logic [7:0]  byte_q;
  logic        end_q;
  logic [31:0] crc;
  logic        crc_busy;
  logic [1:0]  crc_cnt;
  logic [7:0]  sel_byte;
  logic [31:0] crc_in;

  assign cfg_ready    = 1'b1;
  assign sts.can_emit = !crc_busy && (!out_valid || out_ready);
  assign sts.crc_busy = crc_busy;
  assign sts.in_end   = end_q;
  assign crc_in       = {{24{sign_ext & sel_byte[7]}}, sel_byte};

  always_comb begin
    case (cmd.kind)
      fwfb_pkg::KIND_KEY:  sel_byte = start_key;
      fwfb_pkg::KIND_LEN:  sel_byte = fwfb_pkg::FrameLen;
      fwfb_pkg::KIND_CMD:  sel_byte = command_code;
      fwfb_pkg::KIND_ADDR: sel_byte = packet_address[8*cmd.idx +: 8];
      fwfb_pkg::KIND_PLEN: sel_byte = fwfb_pkg::PayloadLen;
      fwfb_pkg::KIND_DATA: sel_byte = byte_q;
      fwfb_pkg::KIND_PAD:  sel_byte = fwfb_pkg::PadByte;
      fwfb_pkg::KIND_CRC:  sel_byte = crc[8*cmd.idx +: 8];
      default:             sel_byte = fwfb_pkg::PadByte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      byte_q <= image_byte;
      end_q  <= image_end;
    end
    if (cmd.emit) begin
      frame_byte <= sel_byte;
      frame_done <= cmd.done;
      run_last   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      packet_address <= '0;
      command_code   <= '0;
      start_key      <= '0;
      crc_poly       <= fwfb_pkg::CrcPolyReset;
      sign_ext       <= 1'b0;
      crc            <= fwfb_pkg::CrcInit;
      crc_busy       <= 1'b0;
      crc_cnt        <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fwfb_pkg::CFG_BASE_ADDRESS:  packet_address <= cfg_data;
          fwfb_pkg::CFG_WRITE_COMMAND: command_code   <= cfg_data[7:0];
          fwfb_pkg::CFG_START_KEY:     start_key      <= cfg_data[7:0];
          fwfb_pkg::CFG_CRC_POLY:      crc_poly       <= cfg_data;
          fwfb_pkg::CFG_SIGN_EXTEND:   sign_ext       <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end
      if (cmd.emit && cmd.take) begin
        crc      <= crc ^ crc_in;
        crc_busy <= 1'b1;
        crc_cnt  <= 2'd0;
      end else if (crc_busy) begin
        crc     <= fwfb_pkg::crc_step8(crc, crc_poly);
        crc_cnt <= crc_cnt + 2'd1;
        if (crc_cnt == 2'd3) begin
          crc_busy <= 1'b0;
        end
      end
      if (cmd.close) begin
        crc            <= fwfb_pkg::CrcInit;
        packet_address <= packet_address + fwfb_pkg::PacketStride;
      end
    end
  end

endmodule

`default_nettype wire
